// ===== design/wgt_pkg.sv =====
package wgt_pkg;

   // wide accumulator: holds n*sxx, sx*sx and the scaled slope numerator
   localparam int ACC_W = 192;
   // narrow multiplier operand and first-order sums (sx, sy)
   localparam int MUL_B_W = 80;

   localparam int MAX_SAMPLES_DEF = 64;

   localparam int CAP_W = 7;
   localparam int TIME_W = 64;
   localparam int BYTES_W = 48;
   localparam int CHANGE_W = 49;
   localparam int SLOPE_W = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
   localparam logic [TIME_W-1:0] WINDOW_RESET = 64'd60000000000;
   localparam logic [TIME_W-1:0] MIN_OBSERVE_NS = 64'd5000000000;
   // 65536 * 1e9: q16 fraction times ns per second
   localparam logic [MUL_B_W-1:0] SLOPE_SCALE = 80'd65536000000000;

   localparam logic [0:0] CSR_CAPACITY = 1'b0;
   localparam logic [0:0] CSR_WINDOW = 1'b1;

   localparam logic [SLOPE_W-1:0] SLOPE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic start;
      logic [ACC_W-1:0] init;
      logic [ACC_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mac_req_type;

endpackage

// ===== design/windowed_growth_trend_detector_core.sv =====
// windowed memory growth trend detector: every request carries a timestamp and a resident
// size; a request whose timestamp is not later than the newest held one is dropped, otherwise
// it is appended to a ring of up to MAX_SAMPLES entries and the oldest entries are evicted
// while the count exceeds sample_capacity or, with more than two entries, while the age span
// exceeds window_span_ns. every request gives one response with count, span, byte change, an
// exact least-squares slope (q16 bytes per second, saturated) and a sustained-growth flag.
// one request is worked at a time and req_stall stays high until its response is taken.
// a request with two or more samples held, stored or dropped, is worked through two products
// per held sample (x*x and x*bytes, with x and bytes as multiplier), five window products
// (count, sy, count, sx, q16 scale as multiplier) and one divide; with fewer than two held
// no product or divide is run, and each eviction adds a ring read and a check step. the
// shift-and-add multiply-accumulate unit works one multiplier bit per cycle and stops when
// no set bit is left, so the run time grows with the bit length of each multiplier, and the
// response is held in ST_OUT while rsp_stall is high. configuration is taken at any time
// (csr_ready is always high) and must only be written while the block is idle.
module windowed_growth_trend_detector_core #(
   parameter int MAX_SAMPLES = wgt_pkg::MAX_SAMPLES_DEF
) (
   input logic clock,
   input logic reset,

   input logic req_valid,
   output logic req_stall,
   input logic [wgt_pkg::TIME_W-1:0] req_sample_time_ns,
   input logic [wgt_pkg::BYTES_W-1:0] req_resident_bytes,

   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_sample_taken,
   output logic [wgt_pkg::CAP_W-1:0] rsp_sample_count,
   output logic rsp_trend_valid,
   output logic [wgt_pkg::TIME_W-1:0] rsp_span_ns,
   output logic signed [wgt_pkg::CHANGE_W-1:0] rsp_rss_change,
   output logic signed [wgt_pkg::SLOPE_W-1:0] rsp_slope_q16,
   output logic rsp_growth_sustained,

   input logic csr_valid,
   output logic csr_ready,
   input logic [0:0] csr_index,
   input logic [wgt_pkg::TIME_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int LW = (CW > wgt_pkg::CAP_W) ? CW + 1 : wgt_pkg::CAP_W + 1;
   localparam int GW = CW + 3;
   localparam int W = wgt_pkg::ACC_W;
   localparam int BW = wgt_pkg::MUL_B_W;
   localparam int TW = wgt_pkg::TIME_W;
   localparam int YW = wgt_pkg::BYTES_W;

   typedef enum logic [26:0] {
      ST_IDLE     = 27'h0000001,
      ST_CHECK    = 27'h0000002,
      ST_EV_RD    = 27'h0000004,
      ST_EV_CHK   = 27'h0000008,
      ST_SUM_RD0  = 27'h0000010,
      ST_SUM_RDL  = 27'h0000020,
      ST_SUM_LAST = 27'h0000040,
      ST_LOOP_RD  = 27'h0000080,
      ST_LOOP_ACC = 27'h0000100,
      ST_XX_GO    = 27'h0000200,
      ST_XX_W     = 27'h0000400,
      ST_XY_GO    = 27'h0000800,
      ST_XY_W     = 27'h0001000,
      ST_N1_GO    = 27'h0002000,
      ST_N1_W     = 27'h0004000,
      ST_N2_GO    = 27'h0008000,
      ST_N2_W     = 27'h0010000,
      ST_D1_GO    = 27'h0020000,
      ST_D1_W     = 27'h0040000,
      ST_D2_GO    = 27'h0080000,
      ST_D2_W     = 27'h0100000,
      ST_SC_GO    = 27'h0200000,
      ST_SC_W     = 27'h0400000,
      ST_DV_GO    = 27'h0800000,
      ST_DV_W     = 27'h1000000,
      ST_FIN      = 27'h2000000,
      ST_OUT      = 27'h4000000
   } state_type;

   // ring slot of the entry k places after base, wrapping at the ring depth
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(k);
      if (s >= (CW+1)'(MAX_SAMPLES)) begin
         s = s - (CW+1)'(MAX_SAMPLES);
      end
      return s[AW-1:0];
   endfunction

   // sample ring, registered read port
   logic [TW-1:0] time_ring_ff [MAX_SAMPLES];
   logic [YW-1:0] bytes_ring_ff [MAX_SAMPLES];
   logic [TW-1:0] rd_time_ff;
   logic [YW-1:0] rd_bytes_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic wr_en;

   state_type state_ff, state_in;
   logic [wgt_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [TW-1:0] window_ff, window_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;

   logic [TW-1:0] t_ff, t_in;
   logic [YW-1:0] y_ff, y_in;
   logic taken_ff, taken_in;
   logic [TW-1:0] t0_ff, t0_in;
   logic [YW-1:0] y0_ff, y0_in;
   logic [TW-1:0] tl_ff, tl_in;
   logic [YW-1:0] yl_ff, yl_in;
   logic [CW-1:0] k_ff, k_in;
   logic [TW-1:0] x_ff, x_in;
   logic [YW-1:0] yk_ff, yk_in;
   logic [YW-1:0] prev_y_ff, prev_y_in;
   logic [YW-1:0] ymid_ff, ymid_in;
   logic [CW-1:0] nondec_ff, nondec_in;
   logic [CW-1:0] inc_ff, inc_in;
   logic [BW-1:0] sx_ff, sx_in;
   logic [BW-1:0] sy_ff, sy_in;
   logic [W-1:0] sxx_ff, sxx_in;
   logic [W-1:0] sxy_ff, sxy_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;
   logic [wgt_pkg::SLOPE_W-1:0] slope_ff, slope_in;

   // response registers
   logic out_trend_ff, out_trend_in;
   logic [TW-1:0] out_span_ff, out_span_in;
   logic [wgt_pkg::CHANGE_W-1:0] out_change_ff, out_change_in;
   logic [wgt_pkg::SLOPE_W-1:0] out_slope_ff, out_slope_in;
   logic out_grow_ff, out_grow_in;

   // shared arithmetic
   wgt_pkg::mac_req_type mac_req;
   logic mac_done;
   logic [W-1:0] mac_acc;
   logic div_start;
   logic div_done;
   logic [W-1:0] div_quo;

   // helpers
   logic taken;
   logic [CW-1:0] cnt_adj;
   logic [AW-1:0] old_adj;
   logic [LW-1:0] cap_wide;
   logic [LW-1:0] cap_eff;
   logic evict;
   logic [W-1:0] sx_neg;
   logic num_neg;
   logic num_pos;
   logic den_pos;
   logic [W-1:0] mag;
   logic [CW-1:0] mid;
   logic [TW-1:0] need;
   logic [TW-1:0] span;
   logic [GW-1:0] n_less;
   logic grow;
   logic quo_high;
   logic [CW+wgt_pkg::CAP_W-1:0] count_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_ready = 1'b1;

   assign count_wide = {{wgt_pkg::CAP_W{1'b0}}, count_ff};
   assign rsp_sample_taken = taken_ff;
   assign rsp_sample_count = count_wide[wgt_pkg::CAP_W-1:0];
   assign rsp_trend_valid = out_trend_ff;
   assign rsp_span_ns = out_span_ff;
   assign rsp_rss_change = out_change_ff;
   assign rsp_slope_q16 = out_slope_ff;
   assign rsp_growth_sustained = out_grow_ff;

   wgt_mac u_mac (
      .clock(clock),
      .reset(reset),
      .req(mac_req),
      .done(mac_done),
      .acc(mac_acc)
   );

   wgt_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(mac_acc),
      .den(den_ff),
      .done(div_done),
      .quo(div_quo)
   );

   // capacity clamped to two .. MAX_SAMPLES
   always_comb begin
      cap_wide = LW'(cap_ff);
      if (cap_wide < LW'(2)) begin
         cap_eff = LW'(2);
      end else if (cap_wide > LW'(MAX_SAMPLES)) begin
         cap_eff = LW'(MAX_SAMPLES);
      end else begin
         cap_eff = cap_wide;
      end
   end

   assign sx_neg = W'(0) - W'(sx_ff);
   assign num_neg = num_ff[W-1];
   assign num_pos = !num_ff[W-1] && (num_ff != '0);
   assign den_pos = !den_ff[W-1] && (den_ff != '0);
   assign mag = num_neg ? (W'(0) - num_ff) : num_ff;
   assign mid = count_ff >> 1;
   assign need = (window_ff < wgt_pkg::MIN_OBSERVE_NS) ? window_ff : wgt_pkg::MIN_OBSERVE_NS;
   assign span = tl_ff - t0_ff;
   assign n_less = GW'(count_ff) - GW'(1);
   assign quo_high = |div_quo[W-1:wgt_pkg::SLOPE_W];

   // new sample must be strictly later than the newest one held
   assign taken = (count_ff == '0) || (t_ff > rd_time_ff);
   assign evict = (LW'(count_ff) > cap_eff) ||
                  ((count_ff > CW'(2)) && ((t_ff - rd_time_ff) > window_ff));

   assign grow = (count_ff >= CW'(4)) && (span >= need) && (yl_ff > y0_ff) &&
                 num_pos && den_pos &&
                 (GW'(nondec_ff) * GW'(3) >= n_less * GW'(2)) &&
                 (inc_ff >= CW'(2)) &&
                 (GW'(inc_ff) * GW'(5) >= n_less) &&
                 (ymid_ff > y0_ff) && (yl_ff > ymid_ff);

   always_comb begin
      state_in = state_ff;
      cap_in = cap_ff;
      window_in = window_ff;
      oldest_in = oldest_ff;
      count_in = count_ff;
      t_in = t_ff;
      y_in = y_ff;
      taken_in = taken_ff;
      t0_in = t0_ff;
      y0_in = y0_ff;
      tl_in = tl_ff;
      yl_in = yl_ff;
      k_in = k_ff;
      x_in = x_ff;
      yk_in = yk_ff;
      prev_y_in = prev_y_ff;
      ymid_in = ymid_ff;
      nondec_in = nondec_ff;
      inc_in = inc_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      num_in = num_ff;
      den_in = den_ff;
      slope_in = slope_ff;
      out_trend_in = out_trend_ff;
      out_span_in = out_span_ff;
      out_change_in = out_change_ff;
      out_slope_in = out_slope_ff;
      out_grow_in = out_grow_ff;
      mac_req = '0;
      div_start = 1'b0;
      wr_en = 1'b0;
      rd_addr = oldest_ff;
      cnt_adj = count_ff;
      old_adj = oldest_ff;
      wr_addr = oldest_ff;

      if (csr_valid) begin
         unique case (csr_index)
            wgt_pkg::CSR_CAPACITY: begin
               cap_in = csr_wdata[wgt_pkg::CAP_W-1:0];
            end
            wgt_pkg::CSR_WINDOW: begin
               window_in = csr_wdata;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // keep the newest timestamp on the read port for the order check
            if (count_ff != '0) begin
               rd_addr = slot(oldest_ff, count_ff - 1'b1);
            end
            if (req_valid) begin
               t_in = req_sample_time_ns;
               y_in = req_resident_bytes;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            taken_in = taken;
            if (taken) begin
               // full ring: drop the oldest before the append
               if (count_ff == CW'(MAX_SAMPLES)) begin
                  cnt_adj = count_ff - 1'b1;
                  old_adj = slot(oldest_ff, CW'(1));
               end
               wr_en = 1'b1;
               wr_addr = slot(old_adj, cnt_adj);
               oldest_in = old_adj;
               count_in = cnt_adj + 1'b1;
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_SUM_RD0;
            end
         end
         ST_EV_RD: begin
            rd_addr = oldest_ff;
            state_in = ST_EV_CHK;
         end
         ST_EV_CHK: begin
            // over capacity or oldest entry too old
            if (evict) begin
               oldest_in = slot(oldest_ff, CW'(1));
               count_in = count_ff - 1'b1;
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_SUM_RD0;
            end
         end
         ST_SUM_RD0: begin
            rd_addr = oldest_ff;
            state_in = (count_ff < CW'(2)) ? ST_FIN : ST_SUM_RDL;
         end
         ST_SUM_RDL: begin
            t0_in = rd_time_ff;
            y0_in = rd_bytes_ff;
            rd_addr = slot(oldest_ff, count_ff - 1'b1);
            state_in = ST_SUM_LAST;
         end
         ST_SUM_LAST: begin
            tl_in = rd_time_ff;
            yl_in = rd_bytes_ff;
            k_in = '0;
            sx_in = '0;
            sy_in = '0;
            sxx_in = '0;
            sxy_in = '0;
            nondec_in = '0;
            inc_in = '0;
            state_in = ST_LOOP_RD;
         end
         ST_LOOP_RD: begin
            rd_addr = slot(oldest_ff, k_ff);
            state_in = ST_LOOP_ACC;
         end
         ST_LOOP_ACC: begin
            // first-order sums and step counts for one entry
            x_in = rd_time_ff - t0_ff;
            yk_in = rd_bytes_ff;
            sx_in = sx_ff + BW'(rd_time_ff - t0_ff);
            sy_in = sy_ff + BW'(rd_bytes_ff);
            if (k_ff != '0) begin
               if (rd_bytes_ff >= prev_y_ff) begin
                  nondec_in = nondec_ff + 1'b1;
               end
               if (rd_bytes_ff > prev_y_ff) begin
                  inc_in = inc_ff + 1'b1;
               end
            end
            prev_y_in = rd_bytes_ff;
            if (k_ff == mid) begin
               ymid_in = rd_bytes_ff;
            end
            state_in = ST_XX_GO;
         end
         ST_XX_GO: begin
            mac_req.start = 1'b1;
            mac_req.init = sxx_ff;
            mac_req.a = W'(x_ff);
            mac_req.b = BW'(x_ff);
            state_in = ST_XX_W;
         end
         ST_XX_W: begin
            if (mac_done) begin
               sxx_in = mac_acc;
               state_in = ST_XY_GO;
            end
         end
         ST_XY_GO: begin
            mac_req.start = 1'b1;
            mac_req.init = sxy_ff;
            mac_req.a = W'(x_ff);
            mac_req.b = BW'(yk_ff);
            state_in = ST_XY_W;
         end
         ST_XY_W: begin
            if (mac_done) begin
               sxy_in = mac_acc;
               k_in = k_ff + 1'b1;
               state_in = ((k_ff + 1'b1) == count_ff) ? ST_N1_GO : ST_LOOP_RD;
            end
         end
         ST_N1_GO: begin
            // numerator: n*sxy - sx*sy
            mac_req.start = 1'b1;
            mac_req.init = '0;
            mac_req.a = sxy_ff;
            mac_req.b = BW'(count_ff);
            state_in = ST_N1_W;
         end
         ST_N1_W: begin
            if (mac_done) begin
               num_in = mac_acc;
               state_in = ST_N2_GO;
            end
         end
         ST_N2_GO: begin
            mac_req.start = 1'b1;
            mac_req.init = num_ff;
            mac_req.a = sx_neg;
            mac_req.b = sy_ff;
            state_in = ST_N2_W;
         end
         ST_N2_W: begin
            if (mac_done) begin
               num_in = mac_acc;
               state_in = ST_D1_GO;
            end
         end
         ST_D1_GO: begin
            // denominator: n*sxx - sx*sx
            mac_req.start = 1'b1;
            mac_req.init = '0;
            mac_req.a = sxx_ff;
            mac_req.b = BW'(count_ff);
            state_in = ST_D1_W;
         end
         ST_D1_W: begin
            if (mac_done) begin
               den_in = mac_acc;
               state_in = ST_D2_GO;
            end
         end
         ST_D2_GO: begin
            mac_req.start = 1'b1;
            mac_req.init = den_ff;
            mac_req.a = sx_neg;
            mac_req.b = sx_ff;
            state_in = ST_D2_W;
         end
         ST_D2_W: begin
            if (mac_done) begin
               den_in = mac_acc;
               state_in = ST_SC_GO;
            end
         end
         ST_SC_GO: begin
            // degenerate window gives a flat slope
            if (den_pos) begin
               mac_req.start = 1'b1;
               mac_req.init = '0;
               mac_req.a = mag;
               mac_req.b = wgt_pkg::SLOPE_SCALE;
               state_in = ST_SC_W;
            end else begin
               slope_in = '0;
               state_in = ST_FIN;
            end
         end
         ST_SC_W: begin
            if (mac_done) begin
               state_in = ST_DV_GO;
            end
         end
         ST_DV_GO: begin
            div_start = 1'b1;
            state_in = ST_DV_W;
         end
         ST_DV_W: begin
            // truncated magnitude, sign restored, saturated to 64 bits
            if (div_done) begin
               if (!num_neg) begin
                  slope_in = (quo_high || div_quo[wgt_pkg::SLOPE_W-1]) ? wgt_pkg::SLOPE_MAX :
                             div_quo[wgt_pkg::SLOPE_W-1:0];
               end else if (quo_high ||
                            (div_quo[wgt_pkg::SLOPE_W-1] &&
                             (div_quo[wgt_pkg::SLOPE_W-2:0] != '0))) begin
                  slope_in = wgt_pkg::SLOPE_MIN;
               end else begin
                  slope_in = wgt_pkg::SLOPE_W'(0) - div_quo[wgt_pkg::SLOPE_W-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (count_ff < CW'(2)) begin
               out_trend_in = 1'b0;
               out_span_in = '0;
               out_change_in = '0;
               out_slope_in = '0;
               out_grow_in = 1'b0;
            end else begin
               out_trend_in = 1'b1;
               out_span_in = span;
               out_change_in = {1'b0, yl_ff} - {1'b0, y0_ff};
               out_slope_in = slope_ff;
               out_grow_in = grow;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_ring_ff[wr_addr] <= t_ff;
         bytes_ring_ff[wr_addr] <= y_ff;
      end
      rd_time_ff <= time_ring_ff[rd_addr];
      rd_bytes_ff <= bytes_ring_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= wgt_pkg::CAP_RESET;
         window_ff <= wgt_pkg::WINDOW_RESET;
         oldest_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         window_ff <= window_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
      end
      t_ff <= t_in;
      y_ff <= y_in;
      taken_ff <= taken_in;
      t0_ff <= t0_in;
      y0_ff <= y0_in;
      tl_ff <= tl_in;
      yl_ff <= yl_in;
      k_ff <= k_in;
      x_ff <= x_in;
      yk_ff <= yk_in;
      prev_y_ff <= prev_y_in;
      ymid_ff <= ymid_in;
      nondec_ff <= nondec_in;
      inc_ff <= inc_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sxx_ff <= sxx_in;
      sxy_ff <= sxy_in;
      num_ff <= num_in;
      den_ff <= den_in;
      slope_ff <= slope_in;
      out_trend_ff <= out_trend_in;
      out_span_ff <= out_span_in;
      out_change_ff <= out_change_in;
      out_slope_ff <= out_slope_in;
      out_grow_ff <= out_grow_in;
   end

endmodule

// ===== design/wgt_mac.sv =====
// shift-and-add multiply-accumulate, one multiplier bit per cycle
module wgt_mac (
   input logic clock,
   input logic reset,
   input wgt_pkg::mac_req_type req,
   output logic done,
   output logic [wgt_pkg::ACC_W-1:0] acc
);

   logic busy_ff, busy_in;
   logic [wgt_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [wgt_pkg::ACC_W-1:0] a_ff, a_in;
   logic [wgt_pkg::MUL_B_W-1:0] b_ff, b_in;

   assign done = busy_ff && (b_ff == '0);
   assign acc = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (req.start) begin
         busy_in = 1'b1;
         acc_in = req.init;
         a_in = req.a;
         b_in = req.b;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[wgt_pkg::ACC_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[wgt_pkg::MUL_B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

// ===== design/wgt_div.sv =====
// restoring divider, one quotient bit per cycle
module wgt_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [wgt_pkg::ACC_W-1:0] num,
   input logic [wgt_pkg::ACC_W-1:0] den,
   output logic done,
   output logic [wgt_pkg::ACC_W-1:0] quo
);

   localparam int CNT_W = $clog2(wgt_pkg::ACC_W + 1);

   logic busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [wgt_pkg::ACC_W-1:0] rem_ff, rem_in;
   logic [wgt_pkg::ACC_W-1:0] quo_ff, quo_in;
   logic [wgt_pkg::ACC_W-1:0] den_ff, den_in;
   logic [wgt_pkg::ACC_W:0] trial;
   logic [wgt_pkg::ACC_W:0] diff;
   logic fits;

   assign done = busy_ff && (cnt_ff == '0);
   assign quo = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[wgt_pkg::ACC_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(wgt_pkg::ACC_W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = fits ? diff[wgt_pkg::ACC_W-1:0] : trial[wgt_pkg::ACC_W-1:0];
            quo_in = {quo_ff[wgt_pkg::ACC_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule
